>>> rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and constants of the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;

    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    localparam logic [3:0] MODE_APPEND  = 4'd0;
    localparam logic [3:0] MODE_INSERT  = 4'd1;
    localparam logic [3:0] MODE_DELETE  = 4'd2;
    localparam logic [3:0] MODE_GET     = 4'd3;
    localparam logic [3:0] MODE_SET     = 4'd4;
    localparam logic [3:0] MODE_LINEAR  = 4'd5;
    localparam logic [3:0] MODE_ORDERED = 4'd6;
    localparam logic [3:0] MODE_TRANSP  = 4'd7;
    localparam logic [3:0] MODE_TOFRONT = 4'd8;
    localparam logic [3:0] MODE_BINARY  = 4'd9;
    localparam logic [3:0] MODE_MAX     = 4'd10;
    localparam logic [3:0] MODE_MIN     = 4'd11;
    localparam logic [3:0] MODE_SUM     = 4'd12;
    localparam logic [3:0] MODE_REVERSE = 4'd13;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [DW-1:0] NEG_ONE = '1;

    typedef struct packed {
        logic [3:0]           mode;
        logic [8:0]           position;
        logic signed [DW-1:0] operand;
    } t_in_beat;

    typedef struct packed {
        logic signed [DW-1:0] result;
        logic [2:0]           status;
        logic [8:0]           count;
    } t_out_beat;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage

>>> rtl/bale_ram.sv
// ----------------------------------------------------------------------------
// bale_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bale_ram
    import bale_pkg::*;
(
    input  logic          i_clk,
    input  t_mem_req      i_req,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bale_seq.sv
// ----------------------------------------------------------------------------
// bale_seq
// Operation sequencer: walks the entry store one entry access at a time.
// ----------------------------------------------------------------------------
module bale_seq
    import bale_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [8:0]    i_cfg_wdata,
    input  logic          i_valid,
    input  t_in_beat      i_beat,
    output logic          o_idle,
    output logic          o_done,
    input  logic          i_take,
    output t_out_beat     o_beat,
    output t_mem_req      o_mem,
    input  logic [DW-1:0] i_rdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_RD    = 6'b000100,
        S_USE   = 6'b001000,
        S_WB    = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [8:0]    r_cap, n_cap;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_mode, n_mode;
    logic [CW-1:0] r_pos, n_pos;
    logic [DW-1:0] r_key, n_key;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_ph, n_ph;
    logic [DW-1:0] r_tmp, n_tmp;
    logic [DW-1:0] r_res, n_res;
    logic [2:0]    r_st, n_st;

    logic [CW-1:0] lim;
    logic [CW-1:0] i_p1, i_p2, lo_n, hi_n, mid_n, mid_s;

    assign lim = (r_cap > DEPTH_CNT) ? DEPTH_CNT : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cap   <= 9'd256;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cap   <= n_cap;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_n    <= n_n;
        r_i    <= n_i;
        r_j    <= n_j;
        r_addr <= n_addr;
        r_ph   <= n_ph;
        r_tmp  <= n_tmp;
        r_res  <= n_res;
        r_st   <= n_st;
    end

    always_comb begin
        n_state = r_state;
        n_cap   = i_cfg_we ? i_cfg_wdata : r_cap;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        n_pos   = r_pos;
        n_key   = r_key;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_addr  = r_addr;
        n_ph    = r_ph;
        n_tmp   = r_tmp;
        n_res   = r_res;
        n_st    = r_st;
        o_mem       = '0;
        o_mem.re    = (r_state == S_RD);
        o_mem.raddr = r_addr;
        i_p1  = r_i + CW'(1);
        i_p2  = r_i + CW'(2);
        lo_n  = r_i;
        hi_n  = r_j;
        mid_n = '0;
        mid_s = (r_n - CW'(1)) >> 1;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_beat.mode;
                    n_pos   = i_beat.position;
                    n_key   = i_beat.operand;
                    n_n     = r_cnt;
                    n_res   = '0;
                    n_st    = ST_OK;
                    n_ph    = 1'b0;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = S_DONE;
                priority case (r_mode)
                    MODE_APPEND: begin
                        if (r_n >= lim) begin
                            n_res = NEG_ONE;
                            n_st  = ST_FULL;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_n[AW-1:0];
                            o_mem.wdata = r_key;
                            n_cnt       = r_n + CW'(1);
                        end
                    end
                    MODE_INSERT: begin
                        if (r_pos > r_n) begin
                            n_res = NEG_ONE;
                            n_st  = ST_BAD_INDEX;
                        end else if (r_n >= lim) begin
                            n_res = NEG_ONE;
                            n_st  = ST_FULL;
                        end else begin
                            n_cnt = r_n + CW'(1);
                            if (r_n > r_pos) begin
                                n_i     = r_n;
                                n_addr  = AW'(r_n - CW'(1));
                                n_state = S_RD;
                            end else begin
                                n_j     = r_pos;
                                n_tmp   = r_key;
                                n_state = S_WB;
                            end
                        end
                    end
                    MODE_DELETE, MODE_GET, MODE_SET: begin
                        if (r_pos >= r_n) begin
                            n_res = NEG_ONE;
                            n_st  = ST_BAD_INDEX;
                        end else if (r_mode == MODE_SET) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_pos[AW-1:0];
                            o_mem.wdata = r_key;
                        end else begin
                            if (r_mode == MODE_DELETE) begin
                                n_cnt = r_n - CW'(1);
                            end
                            n_i     = r_pos;
                            n_addr  = r_pos[AW-1:0];
                            n_state = S_RD;
                        end
                    end
                    MODE_LINEAR, MODE_ORDERED, MODE_TRANSP, MODE_TOFRONT,
                    MODE_BINARY, MODE_MAX, MODE_MIN: begin
                        if (r_n == '0) begin
                            n_res = NEG_ONE;
                            n_st  = ST_EMPTY;
                        end else begin
                            if (r_mode != MODE_MAX && r_mode != MODE_MIN) begin
                                n_res = NEG_ONE;
                                n_st  = ST_NOT_FOUND;
                            end
                            n_i     = '0;
                            n_j     = r_n;
                            n_addr  = (r_mode == MODE_BINARY) ? mid_s[AW-1:0] : '0;
                            n_state = S_RD;
                        end
                    end
                    MODE_SUM: begin
                        if (r_n != '0) begin
                            n_i     = '0;
                            n_addr  = '0;
                            n_state = S_RD;
                        end
                    end
                    MODE_REVERSE: begin
                        if (r_n > CW'(1)) begin
                            n_i     = '0;
                            n_j     = r_n - CW'(1);
                            n_addr  = '0;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                n_state = S_USE;
            end
            S_USE: begin
                n_state = S_DONE;
                priority case (r_mode)
                    MODE_INSERT: begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_i[AW-1:0];
                        o_mem.wdata = i_rdata;
                        n_i         = r_i - CW'(1);
                        if ((r_i - CW'(1)) > r_pos) begin
                            n_addr  = AW'(r_i - CW'(2));
                            n_state = S_RD;
                        end else begin
                            n_j     = r_pos;
                            n_tmp   = r_key;
                            n_state = S_WB;
                        end
                    end
                    MODE_DELETE: begin
                        if (!r_ph) begin
                            n_res = i_rdata;
                            if (i_p1 < r_n) begin
                                n_addr  = i_p1[AW-1:0];
                                n_ph    = 1'b1;
                                n_state = S_RD;
                            end
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_i[AW-1:0];
                            o_mem.wdata = i_rdata;
                            n_i         = i_p1;
                            if (i_p2 < r_n) begin
                                n_addr  = i_p2[AW-1:0];
                                n_state = S_RD;
                            end
                        end
                    end
                    MODE_GET: begin
                        n_res = i_rdata;
                    end
                    MODE_LINEAR, MODE_ORDERED, MODE_TRANSP, MODE_TOFRONT: begin
                        if (r_ph) begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_i[AW-1:0];
                            o_mem.wdata = i_rdata;
                            n_state     = S_WB;
                        end else if (i_rdata == r_key) begin
                            n_st  = ST_OK;
                            n_res = DW'(r_i);
                            if (r_i != '0 && (r_mode == MODE_TRANSP ||
                                              r_mode == MODE_TOFRONT)) begin
                                n_j     = (r_mode == MODE_TRANSP) ? r_i - CW'(1) : '0;
                                n_res   = (r_mode == MODE_TRANSP) ?
                                          DW'(r_i - CW'(1)) : '0;
                                n_addr  = (r_mode == MODE_TRANSP) ?
                                          AW'(r_i - CW'(1)) : '0;
                                n_tmp   = r_key;
                                n_ph    = 1'b1;
                                n_state = S_RD;
                            end
                        end else if (r_mode == MODE_ORDERED &&
                                     $signed(r_key) < $signed(i_rdata)) begin
                            n_state = S_DONE;
                        end else if (i_p1 < r_n) begin
                            n_i     = i_p1;
                            n_addr  = i_p1[AW-1:0];
                            n_state = S_RD;
                        end
                    end
                    MODE_BINARY: begin
                        if (i_rdata == r_key) begin
                            n_st  = ST_OK;
                            n_res = DW'(r_addr);
                        end else begin
                            if ($signed(i_rdata) < $signed(r_key)) begin
                                lo_n = CW'(r_addr) + CW'(1);
                            end else begin
                                hi_n = CW'(r_addr);
                            end
                            mid_n = lo_n + ((hi_n - CW'(1) - lo_n) >> 1);
                            n_i   = lo_n;
                            n_j   = hi_n;
                            if (lo_n < hi_n) begin
                                n_addr  = mid_n[AW-1:0];
                                n_state = S_RD;
                            end
                        end
                    end
                    MODE_MAX, MODE_MIN, MODE_SUM: begin
                        if (r_mode == MODE_SUM) begin
                            n_res = r_res + i_rdata;
                        end else if (!r_ph) begin
                            n_res = i_rdata;
                        end else if (r_mode == MODE_MAX ?
                                     $signed(r_res) < $signed(i_rdata) :
                                     $signed(i_rdata) < $signed(r_res)) begin
                            n_res = i_rdata;
                        end
                        n_ph = 1'b1;
                        if (i_p1 < r_n) begin
                            n_i     = i_p1;
                            n_addr  = i_p1[AW-1:0];
                            n_state = S_RD;
                        end
                    end
                    MODE_REVERSE: begin
                        if (!r_ph) begin
                            n_tmp   = i_rdata;
                            n_addr  = r_j[AW-1:0];
                            n_ph    = 1'b1;
                            n_state = S_RD;
                        end else begin
                            o_mem.we    = 1'b1;
                            o_mem.waddr = r_i[AW-1:0];
                            o_mem.wdata = i_rdata;
                            n_state     = S_WB;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WB: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_j[AW-1:0];
                o_mem.wdata = r_tmp;
                n_state     = S_DONE;
                if (r_mode == MODE_REVERSE) begin
                    n_i  = i_p1;
                    n_j  = r_j - CW'(1);
                    n_ph = 1'b0;
                    if (i_p1 < (r_j - CW'(1))) begin
                        n_addr  = i_p1[AW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle        = (r_state == S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_beat.result = r_res;
    assign o_beat.status = r_st;
    assign o_beat.count  = r_cnt;

endmodule

>>> rtl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded list of signed words with shift, search and reduction operations.
// ----------------------------------------------------------------------------
//   channel   signals                              direction
//   input     i_in_valid  o_in_stall  i_in_beat    in
//   output    o_out_valid i_out_stall o_out_beat   out
//   config    i_cfg_we    i_cfg_wdata              in
//
// one item at a time; each stored entry visited is read and then used
// (S_RD, S_USE) through the single read port of the store
// reverse swaps each pair by reading both entries, then writing them back
// reset clears the count and sets capacity to 256; the store is not cleared
// a new beat is taken while the previous result waits in the output register
module bounded_array_list_engine
    import bale_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [8:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_mem_req      mem_req;
    logic [DW-1:0] mem_rdata;
    logic          seq_idle;
    logic          seq_done;
    logic          take;
    t_out_beat     seq_beat;

    logic      r_ov;
    t_out_beat r_ob;

    bale_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bale_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in_valid),
        .i_beat      (i_in_beat),
        .o_idle      (seq_idle),
        .o_done      (seq_done),
        .i_take      (take),
        .o_beat      (seq_beat),
        .o_mem       (mem_req),
        .i_rdata     (mem_rdata)
    );

    assign take = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (take) begin
            r_ov <= seq_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && seq_done) begin
            r_ob <= seq_beat;
        end
    end

    assign o_in_stall  = !seq_idle;
    assign o_out_valid = r_ov;
    assign o_out_beat  = r_ob;

endmodule

>>> verif/tb_bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine
// Drives list operations through the valid/stall input channel with random
// gaps, predicts every result with a behavioral copy of the list, and checks
// result, status and count beat by beat. Capacity is changed between phases.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine;
    import bale_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 1330;

    typedef struct {
        t_in_beat  beat;
        logic      has_fixed;
        t_out_beat fixed;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [8:0] i_cfg_wdata;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_beat;

    bounded_array_list_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    logic [DW-1:0] list_words [DEPTH];
    int unsigned   list_len;
    int unsigned   cap_reg;
    t_out_beat     pending_results [$];
    t_row          rows [$];
    int            n_mismatch;
    int            idle_cycles;
    bit            timed_out;
    bit            stall_enable;
    int unsigned   out_wait;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_in_beat mk(logic [3:0] m, int unsigned p, logic [DW-1:0] v);
        t_in_beat b;
        b.mode     = m;
        b.position = p[8:0];
        b.operand  = v;
        return b;
    endfunction

    function automatic t_out_beat ob(logic [DW-1:0] r, logic [2:0] s, int unsigned c);
        t_out_beat o;
        o.result = r;
        o.status = s;
        o.count  = c[8:0];
        return o;
    endfunction

    function automatic bit s_lt(logic [DW-1:0] a, logic [DW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic t_out_beat apply_list_op(t_in_beat b);
        logic [DW-1:0] res, t;
        logic [2:0]    st;
        int unsigned   n, lim, p, lo, hi, mid, a, z;
        n   = list_len;
        lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        p   = b.position;
        res = '0;
        st  = ST_OK;
        case (b.mode)
            MODE_APPEND: begin
                if (n >= lim) begin
                    res = NEG_ONE; st = ST_FULL;
                end else begin
                    list_words[n] = b.operand; list_len++;
                end
            end
            MODE_INSERT: begin
                if (p > n) begin
                    res = NEG_ONE; st = ST_BAD_INDEX;
                end else if (n >= lim) begin
                    res = NEG_ONE; st = ST_FULL;
                end else begin
                    for (int i = n; i > p; i--) list_words[i] = list_words[i-1];
                    list_words[p] = b.operand; list_len++;
                end
            end
            MODE_DELETE, MODE_GET, MODE_SET: begin
                if (p >= n) begin
                    res = NEG_ONE; st = ST_BAD_INDEX;
                end else if (b.mode == MODE_SET) begin
                    list_words[p] = b.operand;
                end else begin
                    res = list_words[p];
                    if (b.mode == MODE_DELETE) begin
                        for (int i = p; i + 1 < n; i++) list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
            end
            MODE_LINEAR, MODE_ORDERED, MODE_TRANSP, MODE_TOFRONT: begin
                if (n == 0) begin
                    res = NEG_ONE; st = ST_EMPTY;
                end else begin
                    res = NEG_ONE; st = ST_NOT_FOUND;
                    for (int i = 0; i < n; i++) begin
                        if (list_words[i] == b.operand) begin
                            st = ST_OK; res = i;
                            if (i > 0 && b.mode == MODE_TRANSP) begin
                                t = list_words[i]; list_words[i] = list_words[i-1];
                                list_words[i-1] = t; res = i - 1;
                            end
                            if (i > 0 && b.mode == MODE_TOFRONT) begin
                                t = list_words[i]; list_words[i] = list_words[0];
                                list_words[0] = t; res = 0;
                            end
                            break;
                        end
                        if (b.mode == MODE_ORDERED && s_lt(b.operand, list_words[i])) break;
                    end
                end
            end
            MODE_BINARY: begin
                if (n == 0) begin
                    res = NEG_ONE; st = ST_EMPTY;
                end else begin
                    res = NEG_ONE; st = ST_NOT_FOUND; lo = 0; hi = n;
                    while (lo < hi) begin
                        mid = lo + (hi - 1 - lo) / 2;
                        if (list_words[mid] == b.operand) begin
                            res = mid; st = ST_OK; break;
                        end
                        if (s_lt(list_words[mid], b.operand)) lo = mid + 1;
                        else hi = mid;
                    end
                end
            end
            MODE_MAX, MODE_MIN: begin
                if (n == 0) begin
                    res = NEG_ONE; st = ST_EMPTY;
                end else begin
                    res = list_words[0];
                    for (int i = 1; i < n; i++)
                        if (b.mode == MODE_MAX ? s_lt(res, list_words[i])
                                               : s_lt(list_words[i], res))
                            res = list_words[i];
                end
            end
            MODE_SUM: begin
                for (int i = 0; i < n; i++) res += list_words[i];
            end
            MODE_REVERSE: begin
                if (n > 1) begin
                    a = 0; z = n - 1;
                    while (a < z) begin
                        t = list_words[a]; list_words[a] = list_words[z];
                        list_words[z] = t; a++; z--;
                    end
                end
            end
            default: ;
        endcase
        return ob(res, st, list_len);
    endfunction

    // operands biased toward values already stored so searches hit
    function automatic logic [DW-1:0] pick_operand();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
        if (r == 4) return 32'h7FFF_FFFF;
        if (r == 5) return 32'h8000_0000;
        if (r < 8) return $urandom_range(0, 40) - 20;
        return $urandom;
    endfunction

    function automatic int unsigned pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 511);
        if (r == 1) return list_len;
        return $urandom_range(0, list_len + 1);
    endfunction

    function automatic logic [3:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        // growth-heavy while short so deep lists appear
        if (list_len < 8 && r < 40) return MODE_APPEND;
        if (r < 15) return MODE_APPEND;
        if (r < 25) return MODE_INSERT;
        if (r < 33) return MODE_DELETE;
        if (r == 99) return 4'($urandom_range(14, 15));
        return 4'($urandom_range(3, 13));
    endfunction

    // valid stays high after the accepting edge until the next call, in the same step
    task automatic send_beat(t_in_beat b);
        int unsigned gap;
        gap = $urandom_range(0, 19);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_list_op(b));
    endtask

    task automatic drain_and_set_capacity(int unsigned cap);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap[8:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = cap;
    endtask

    // output side: a wait drawn for every beat, phases without stall
    always @(posedge i_clk) begin
        int unsigned w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            w = stall_enable ? $urandom_range(0, 19) : 0;
            out_wait    <= w;
            i_out_stall <= (w != 0);
        end else if (o_out_valid && i_out_stall) begin
            out_wait    <= out_wait - 1;
            i_out_stall <= (out_wait > 1);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected beat %p", o_out_beat);
            end else begin
                want = pending_results.pop_front();
                if (o_out_beat.result !== want.result || o_out_beat.status !== want.status
                    || o_out_beat.count !== want.count) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch exp %p got %p", want, o_out_beat);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_out_beat got;
        n_mismatch   = 0;
        idle_cycles  = 0;
        timed_out    = 0;
        stall_enable = 0;
        list_len     = 0;
        cap_reg      = 256;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_beat    = '0;

        // directed rows: fixed results only where obvious
        rows.push_back('{mk(MODE_GET, 0, 0), 1, ob(NEG_ONE, ST_BAD_INDEX, 0)});
        rows.push_back('{mk(MODE_LINEAR, 0, 5), 1, ob(NEG_ONE, ST_EMPTY, 0)});
        rows.push_back('{mk(MODE_BINARY, 0, 5), 1, ob(NEG_ONE, ST_EMPTY, 0)});
        rows.push_back('{mk(MODE_MAX, 0, 0), 1, ob(NEG_ONE, ST_EMPTY, 0)});
        rows.push_back('{mk(MODE_MIN, 0, 0), 1, ob(NEG_ONE, ST_EMPTY, 0)});
        rows.push_back('{mk(MODE_SUM, 0, 0), 1, ob(0, ST_OK, 0)});
        rows.push_back('{mk(MODE_REVERSE, 0, 0), 1, ob(0, ST_OK, 0)});
        rows.push_back('{mk(MODE_DELETE, 511, 0), 1, ob(NEG_ONE, ST_BAD_INDEX, 0)});
        rows.push_back('{mk(MODE_INSERT, 1, 0), 1, ob(NEG_ONE, ST_BAD_INDEX, 0)});
        rows.push_back('{mk(MODE_APPEND, 0, 32'h8000_0000), 1, ob(0, ST_OK, 1)});
        rows.push_back('{mk(MODE_APPEND, 0, 32'h7FFF_FFFF), 1, ob(0, ST_OK, 2)});
        rows.push_back('{mk(MODE_INSERT, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk(MODE_INSERT, 3, 7), 0, '0});
        rows.push_back('{mk(MODE_SET, 1, 3), 0, '0});
        rows.push_back('{mk(MODE_GET, 3, 0), 0, '0});
        rows.push_back('{mk(MODE_SUM, 0, 0), 0, '0});
        rows.push_back('{mk(MODE_MAX, 0, 0), 0, '0});
        rows.push_back('{mk(MODE_MIN, 0, 0), 0, '0});
        rows.push_back('{mk(MODE_ORDERED, 0, 32'h7FFF_FFFF), 0, '0});
        rows.push_back('{mk(MODE_TRANSP, 0, 7), 0, '0});
        rows.push_back('{mk(MODE_TOFRONT, 0, 32'h7FFF_FFFF), 0, '0});
        rows.push_back('{mk(MODE_BINARY, 0, 3), 0, '0});
        rows.push_back('{mk(MODE_LINEAR, 0, 12345), 0, '0});
        rows.push_back('{mk(MODE_REVERSE, 0, 0), 0, '0});
        rows.push_back('{mk(4'd15, 511, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk(MODE_DELETE, 0, 0), 0, '0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_beat(rows[k].beat);
            if (rows[k].has_fixed) begin
                got = pending_results[$];
                if (got !== rows[k].fixed) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("table row %0d exp %p model %p", k, rows[k].fixed, got);
                end
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            int unsigned cap;
            case (ph)
                0: cap = 0;
                1: cap = 1;
                2: cap = 3;
                3: cap = 16;
                4: cap = 511;
                default: cap = 256;
            endcase
            drain_and_set_capacity(cap);
            stall_enable = (ph % 2 == 1);
            for (int k = 0; k < N_RANDOM / 6; k++)
                send_beat(mk(pick_mode(), pick_position(), pick_operand()));
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
